>>> hw/rtl/gcl_pkg.sv
// ============================================================================
// gcl_pkg
// Shared constants, types and helpers for the GARCH covariate likelihood block.
// ============================================================================
package gcl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_COV    = 4;
    localparam int COV_IDX_W  = 2;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 48;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = 6;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARCH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GARCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT    = 3'd7;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] MAX32 = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [WIDE_W-1:0] MAX48 = 48'sh7fff_ffff_ffff;
    localparam logic signed [WIDE_W-1:0] MIN48 = 48'sh8000_0000_0000;

    // square root of (variance << FRAC_BITS), one result bit per cycle
    localparam int RAD_W      = 31 + FRAC_BITS;
    localparam int SQRT_STEPS = (RAD_W + 1) / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int NUM_W      = 63;
    localparam int DEN_W      = 2 * ROOT_W + 2;
    localparam int QUO_W      = WIDE_W - 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int LOG_STEPS  = FRAC_BITS;
    localparam int P_W        = 5;

    localparam logic signed [MUL_W-1:0] LN2_Q32 = 33'sd2977044472;
    localparam longint HALF_LN_2PI_Q32 = 64'd3946810947;
    localparam longint HALF_LN_2PI_Q =
        (HALF_LN_2PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] BAD_TOTAL_Q = WIDE_W'(64'd999999 << FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_OM_M, S_OM_W, S_WA_M, S_WA_W, S_CW_M, S_CW_W, S_START,
        S_LS_M, S_LS_W, S_AL_M, S_AL_W, S_SG_M, S_SG_W, S_BE_M, S_BE_W,
        S_CHECK, S_SQRT, S_XX_M, S_XX_W, S_SS_M, S_SS_W, S_LG_INIT,
        S_Y_M, S_Y_W, S_LN_M, S_LN_W, S_DV_INIT, S_DIV, S_TERM, S_COMMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_M_OM, OP_W_OM, OP_M_WA, OP_W_WA, OP_M_CW, OP_W_CW,
        OP_START, OP_M_LS, OP_W_LS, OP_M_AL, OP_W_AL, OP_M_SG, OP_W_SG,
        OP_M_BE, OP_W_BE, OP_CHECK, OP_SQ_STEP, OP_M_XX, OP_W_XX, OP_M_SS,
        OP_W_SS, OP_LG_INIT, OP_M_Y, OP_W_Y, OP_M_LN, OP_W_LN, OP_DV_INIT,
        OP_DV_STEP, OP_TERM, OP_COMMIT
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [COV_IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic start;
        logic var_neg;
        logic div_sat;
        logic out_free;
    } t_status;

    // floor(p / 2^FRAC_BITS), saturated to signed 32 bits
    function automatic logic signed [DATA_W-1:0] qsat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if (sh > PROD_W'(MAX32)) begin
            return MAX32;
        end else if (sh < PROD_W'(MIN32)) begin
            return MIN32;
        end
        return sh[DATA_W-1:0];
    endfunction

endpackage

>>> hw/rtl/gcl_ctrl.sv
// ============================================================================
// gcl_ctrl
// Sequencer: steps the shared datapath through one sample's computation.
// ============================================================================
module gcl_ctrl import gcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE:    if (i_valid) n_state = S_OM_M;
            S_OM_M:    n_state = S_OM_W;
            S_OM_W:    n_state = S_WA_M;
            S_WA_M: begin
                n_state = S_WA_W;
                n_cnt   = r_cnt;
            end
            S_WA_W: begin
                n_state = S_CW_M;
                n_cnt   = r_cnt;
            end
            S_CW_M: begin
                n_state = S_CW_W;
                n_cnt   = r_cnt;
            end
            S_CW_W: begin
                if (r_cnt == CNT_W'(NUM_COV - 1)) begin
                    n_state = i_status.start ? S_START : S_LS_M;
                end else begin
                    n_state = S_WA_M;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            S_START:   n_state = S_COMMIT;
            S_LS_M:    n_state = S_LS_W;
            S_LS_W:    n_state = S_AL_M;
            S_AL_M:    n_state = S_AL_W;
            S_AL_W:    n_state = S_SG_M;
            S_SG_M:    n_state = S_SG_W;
            S_SG_W:    n_state = S_BE_M;
            S_BE_M:    n_state = S_BE_W;
            S_BE_W:    n_state = S_CHECK;
            S_CHECK:   n_state = i_status.var_neg ? S_COMMIT : S_SQRT;
            S_SQRT: begin
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_XX_M;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_XX_M:    n_state = S_XX_W;
            S_XX_W:    n_state = S_SS_M;
            S_SS_M:    n_state = S_SS_W;
            S_SS_W:    n_state = S_LG_INIT;
            S_LG_INIT: n_state = S_Y_M;
            S_Y_M: begin
                n_state = S_Y_W;
                n_cnt   = r_cnt;
            end
            S_Y_W: begin
                if (r_cnt == CNT_W'(LOG_STEPS - 1)) begin
                    n_state = S_LN_M;
                end else begin
                    n_state = S_Y_M;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            S_LN_M:    n_state = S_LN_W;
            S_LN_W:    n_state = S_DV_INIT;
            S_DV_INIT: n_state = i_status.div_sat ? S_TERM : S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_TERM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_TERM:    n_state = S_COMMIT;
            S_COMMIT:  if (i_status.out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // command to datapath
    always_comb begin
        o_ready    = (r_state == S_IDLE);
        o_cmd.idx  = r_cnt[COV_IDX_W-1:0];
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE:    o_cmd.op = i_valid ? OP_LOAD : OP_NONE;
            S_OM_M:    o_cmd.op = OP_M_OM;
            S_OM_W:    o_cmd.op = OP_W_OM;
            S_WA_M:    o_cmd.op = OP_M_WA;
            S_WA_W:    o_cmd.op = OP_W_WA;
            S_CW_M:    o_cmd.op = OP_M_CW;
            S_CW_W:    o_cmd.op = OP_W_CW;
            S_START:   o_cmd.op = OP_START;
            S_LS_M:    o_cmd.op = OP_M_LS;
            S_LS_W:    o_cmd.op = OP_W_LS;
            S_AL_M:    o_cmd.op = OP_M_AL;
            S_AL_W:    o_cmd.op = OP_W_AL;
            S_SG_M:    o_cmd.op = OP_M_SG;
            S_SG_W:    o_cmd.op = OP_W_SG;
            S_BE_M:    o_cmd.op = OP_M_BE;
            S_BE_W:    o_cmd.op = OP_W_BE;
            S_CHECK:   o_cmd.op = OP_CHECK;
            S_SQRT:    o_cmd.op = OP_SQ_STEP;
            S_XX_M:    o_cmd.op = OP_M_XX;
            S_XX_W:    o_cmd.op = OP_W_XX;
            S_SS_M:    o_cmd.op = OP_M_SS;
            S_SS_W:    o_cmd.op = OP_W_SS;
            S_LG_INIT: o_cmd.op = OP_LG_INIT;
            S_Y_M:     o_cmd.op = OP_M_Y;
            S_Y_W:     o_cmd.op = OP_W_Y;
            S_LN_M:    o_cmd.op = OP_M_LN;
            S_LN_W:    o_cmd.op = OP_W_LN;
            S_DV_INIT: o_cmd.op = OP_DV_INIT;
            S_DIV:     o_cmd.op = OP_DV_STEP;
            S_TERM:    o_cmd.op = OP_TERM;
            S_COMMIT:  o_cmd.op = i_status.out_free ? OP_COMMIT : OP_NONE;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/gcl_dpath.sv
// ============================================================================
// gcl_dpath
// Datapath: config registers, one shared multiplier, root, log and divide
// step logic, series state and the output register.
// ============================================================================
module gcl_dpath import gcl_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [DATA_W-1:0]           i_cfg_data,
    input  logic signed [DATA_W-1:0]    i_x_sample,
    input  logic signed [DATA_W-1:0]    i_cov [NUM_COV],
    input  logic                        i_series_start,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [DATA_W-1:0]    o_sigma_out,
    output logic signed [WIDE_W-1:0]    o_nll_term,
    output logic signed [WIDE_W-1:0]    o_nll_total,
    output logic                        o_bad_variance
);

    logic signed [DATA_W-1:0]   r_cfg [NUM_REGS];
    logic signed [DATA_W-1:0]   r_x;
    logic signed [DATA_W-1:0]   r_cov [NUM_COV];
    logic                       r_start;
    logic signed [DATA_W-1:0]   r_a, r_om, r_t;
    logic signed [DATA_W+1:0]   r_covsum;
    logic signed [DATA_W+2:0]   r_var;
    logic                       r_neg;
    logic signed [DATA_W-1:0]   r_sigma;
    logic signed [PROD_W-1:0]   r_prod;
    logic [RAD_W-1:0]           r_rad, r_root, r_bit;
    logic [NUM_W-1:0]           r_num;
    logic [DEN_W-1:0]           r_den;
    logic [DATA_W-1:0]          r_y;
    logic [P_W-1:0]             r_p;
    logic [FRAC_BITS-1:0]       r_frac;
    logic signed [PROD_W-DATA_W-1:0] r_ln;
    logic                       r_dsat;
    logic [REM_W-1:0]           r_rem;
    logic [RAD_W-1:0]           r_dsh;
    logic [QUO_W-1:0]           r_quo;
    logic signed [WIDE_W-1:0]   r_term;
    // series state
    logic signed [DATA_W-1:0]   r_last_x, r_last_sig;
    logic signed [WIDE_W-1:0]   r_total;
    logic                       r_sticky;
    // output register
    logic                       r_ovalid;
    logic signed [DATA_W-1:0]   r_o_sigma;
    logic signed [WIDE_W-1:0]   r_o_term, r_o_total;
    logic                       r_o_bad;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic [CFG_IDX_W-1:0]       w_idx;
    logic [ROOT_W-1:0]          s_val;
    logic signed [DATA_W+1:0]   a_diff;
    logic signed [DATA_W-1:0]   a_sat, init_abs, qp;
    logic [RAD_W:0]             sq_trial;
    logic [P_W-1:0]             msb_pos;
    logic [DATA_W-1:0]          y_next;
    logic signed [MUL_W-1:0]    l_val;
    logic                       div_sat;
    logic [REM_W-1:0]           rem_shift;
    logic signed [WIDE_W+1:0]   term_sum;
    logic signed [WIDE_W:0]     total_sum;
    logic signed [WIDE_W-1:0]   q48, total_new;
    logic                       sticky_new;
    logic                       out_free;

    assign w_idx    = REG_WEIGHT0 + CFG_IDX_W'(i_cmd.idx);
    assign s_val    = (r_sigma == '0) ? ROOT_W'(1) : r_sigma[ROOT_W-1:0];
    assign qp       = qsat(r_prod);
    assign out_free = !r_ovalid || i_out_ready;

    // a = 1 - alpha - beta, saturated
    always_comb begin
        a_diff = (DATA_W+2)'(ONE_Q) - (DATA_W+2)'(r_cfg[REG_ARCH])
               - (DATA_W+2)'(r_cfg[REG_GARCH]);
        if (a_diff > (DATA_W+2)'(MAX32)) begin
            a_sat = MAX32;
        end else if (a_diff < (DATA_W+2)'(MIN32)) begin
            a_sat = MIN32;
        end else begin
            a_sat = a_diff[DATA_W-1:0];
        end
    end

    // magnitude of the starting sigma
    always_comb begin
        if (r_cfg[REG_INIT] == MIN32) begin
            init_abs = MAX32;
        end else if (r_cfg[REG_INIT] < 0) begin
            init_abs = -r_cfg[REG_INIT];
        end else begin
            init_abs = r_cfg[REG_INIT];
        end
    end

    // leading one of s for the log normalization
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < ROOT_W; i++) begin
            if (s_val[i]) msb_pos = P_W'(i);
        end
    end

    // shared multiplier operand select
    always_comb begin
        l_val = (MUL_W'(r_p) << FRAC_BITS) + MUL_W'(r_frac)
              - MUL_W'(FRAC_BITS << FRAC_BITS);
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_M_OM: begin
                mul_a = MUL_W'(r_cfg[REG_OMEGA]);
                mul_b = MUL_W'(r_a);
            end
            OP_M_WA: begin
                mul_a = MUL_W'(r_cfg[w_idx]);
                mul_b = MUL_W'(r_a);
            end
            OP_M_CW: begin
                mul_a = MUL_W'(r_cov[i_cmd.idx]);
                mul_b = MUL_W'(r_t);
            end
            OP_M_LS: begin
                mul_a = MUL_W'(r_last_x);
                mul_b = MUL_W'(r_last_x);
            end
            OP_M_AL: begin
                mul_a = MUL_W'(r_cfg[REG_ARCH]);
                mul_b = MUL_W'(r_t);
            end
            OP_M_SG: begin
                mul_a = MUL_W'(r_last_sig);
                mul_b = MUL_W'(r_last_sig);
            end
            OP_M_BE: begin
                mul_a = MUL_W'(r_cfg[REG_GARCH]);
                mul_b = MUL_W'(r_t);
            end
            OP_M_XX: begin
                mul_a = MUL_W'(r_x);
                mul_b = MUL_W'(r_x);
            end
            OP_M_SS: begin
                mul_a = MUL_W'(s_val);
                mul_b = MUL_W'(s_val);
            end
            OP_M_Y: begin
                mul_a = MUL_W'(r_y);
                mul_b = MUL_W'(r_y);
            end
            OP_M_LN: begin
                mul_a = l_val;
                mul_b = LN2_Q32;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // step helpers for root, log, divide, term and commit
    always_comb begin
        sq_trial  = (RAD_W+1)'(r_root) + (RAD_W+1)'(r_bit);
        y_next    = r_prod[2*DATA_W-3:DATA_W-2];
        div_sat   = (DEN_W'(r_num[NUM_W-1:QUO_W-FRAC_BITS]) >= r_den);
        rem_shift = {r_rem[REM_W-2:0], r_dsh[RAD_W-1]};
        q48       = r_dsat ? MAX48 : WIDE_W'(r_quo);
        term_sum  = (WIDE_W+2)'(HALF_LN_2PI_Q) + (WIDE_W+2)'(r_ln) + (WIDE_W+2)'(q48);
        total_sum = (WIDE_W+1)'(r_total) + (WIDE_W+1)'(r_term);
        if (r_start) begin
            total_new  = '0;
            sticky_new = 1'b0;
        end else if (r_neg) begin
            total_new  = r_total;
            sticky_new = 1'b1;
        end else begin
            sticky_new = r_sticky;
            if (total_sum > (WIDE_W+1)'(MAX48)) begin
                total_new = MAX48;
            end else if (total_sum < (WIDE_W+1)'(MIN48)) begin
                total_new = MIN48;
            end else begin
                total_new = total_sum[WIDE_W-1:0];
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[REG_OMEGA] <= ONE_Q;
            r_cfg[REG_INIT]  <= ONE_Q;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // series state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x   <= '0;
            r_last_sig <= '0;
            r_total    <= '0;
            r_sticky   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (i_cmd.op == OP_COMMIT) begin
                r_last_x   <= r_x;
                r_last_sig <= r_sigma;
                r_total    <= total_new;
                r_sticky   <= sticky_new;
                r_ovalid   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_COMMIT) begin
            r_o_sigma <= r_sigma;
            r_o_term  <= r_term;
            r_o_total <= sticky_new ? BAD_TOTAL_Q : total_new;
            r_o_bad   <= sticky_new;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            OP_LOAD: begin
                r_x      <= i_x_sample;
                r_cov    <= i_cov;
                r_start  <= i_series_start;
                r_a      <= a_sat;
                r_covsum <= '0;
                r_neg    <= 1'b0;
                r_term   <= '0;
            end
            OP_W_OM:  r_om <= qp;
            OP_W_WA:  r_t  <= qp;
            OP_W_CW:  r_covsum <= r_covsum + (DATA_W+2)'(qp);
            OP_START: begin
                if (init_abs != '0) begin
                    r_sigma <= init_abs;
                end else if (r_covsum > (DATA_W+2)'(MAX32)) begin
                    r_sigma <= MAX32;
                end else if (r_covsum < (DATA_W+2)'(MIN32)) begin
                    r_sigma <= MIN32;
                end else begin
                    r_sigma <= r_covsum[DATA_W-1:0];
                end
            end
            OP_W_LS:  r_t <= qp;
            OP_W_AL:  r_var <= (DATA_W+3)'(r_om) + (DATA_W+3)'(r_covsum) + (DATA_W+3)'(qp);
            OP_W_SG:  r_t <= qp;
            OP_W_BE:  r_var <= r_var + (DATA_W+3)'(qp);
            OP_CHECK: begin
                if (r_var < 0) begin
                    r_neg   <= 1'b1;
                    r_sigma <= '0;
                end else if (r_var > (DATA_W+3)'(MAX32)) begin
                    r_rad <= RAD_W'(MAX32) << FRAC_BITS;
                end else begin
                    r_rad <= RAD_W'(r_var) << FRAC_BITS;
                end
                r_root <= '0;
                r_bit  <= RAD_W'(1) << (2 * (SQRT_STEPS - 1));
            end
            OP_SQ_STEP: begin
                if ((RAD_W+1)'(r_rad) >= sq_trial) begin
                    r_rad  <= r_rad - sq_trial[RAD_W-1:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_M_XX:  r_sigma <= DATA_W'(r_root);
            OP_W_XX:  r_num <= r_prod[NUM_W-1:0];
            OP_W_SS:  r_den <= {r_prod[DEN_W-2:0], 1'b0};
            OP_LG_INIT: begin
                r_p    <= msb_pos;
                r_y    <= DATA_W'(s_val) << (P_W'(30) - msb_pos);
                r_frac <= '0;
            end
            OP_W_Y: begin
                if (y_next[DATA_W-1]) begin
                    r_y    <= y_next >> 1;
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_y    <= y_next;
                    r_frac <= {r_frac[FRAC_BITS-2:0], 1'b0};
                end
            end
            OP_W_LN:  r_ln <= r_prod[PROD_W-1:DATA_W];
            OP_DV_INIT: begin
                r_dsat <= div_sat;
                r_rem  <= REM_W'(r_num[NUM_W-1:QUO_W-FRAC_BITS]);
                r_dsh  <= {r_num[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                r_quo  <= '0;
            end
            OP_DV_STEP: begin
                if (rem_shift >= REM_W'(r_den)) begin
                    r_rem <= rem_shift - REM_W'(r_den);
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_shift;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh << 1;
            end
            OP_TERM: begin
                if (term_sum > (WIDE_W+2)'(MAX48)) begin
                    r_term <= MAX48;
                end else if (term_sum < (WIDE_W+2)'(MIN48)) begin
                    r_term <= MIN48;
                end else begin
                    r_term <= term_sum[WIDE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.start    = r_start;
    assign o_status.var_neg  = r_var[DATA_W+2];
    assign o_status.div_sat  = div_sat;
    assign o_status.out_free = out_free;

    assign o_out_valid    = r_ovalid;
    assign o_sigma_out    = r_o_sigma;
    assign o_nll_term     = r_o_term;
    assign o_nll_total    = r_o_total;
    assign o_bad_variance = r_o_bad;

endmodule

>>> hw/rtl/garch_covariate_likelihood.sv
// ============================================================================
// garch_covariate_likelihood
// GARCH(1,1) Gaussian negative log likelihood with covariates, Q16.16.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     i_valid / o_ready    x_sample, cov_0..cov_3, series_start
//  output    o_valid / i_ready    sigma_out, nll_term, nll_total, bad_variance
//  config    i_cfg_we             i_cfg_idx, i_cfg_data (write only)
//
//  One sample at a time. A later item of a series runs the shared 33x33
//  multiplier, a 24-step root, a 16-step log squaring loop and a 47-step
//  restoring divide back to back; a first item skips the root, log and divide.
//  Reset is synchronous, active low; no clearing pass.
//  The result waits in an output register; the next request is taken meanwhile,
//  and its commit holds until the output register is free.
module garch_covariate_likelihood import gcl_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_x_sample,
    input  logic signed [DATA_W-1:0] i_cov_0,
    input  logic signed [DATA_W-1:0] i_cov_1,
    input  logic signed [DATA_W-1:0] i_cov_2,
    input  logic signed [DATA_W-1:0] i_cov_3,
    input  logic                     i_series_start,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_sigma_out,
    output logic signed [WIDE_W-1:0] o_nll_term,
    output logic signed [WIDE_W-1:0] o_nll_total,
    output logic                     o_bad_variance
);

    t_cmd                     cmd;
    t_status                  status;
    logic signed [DATA_W-1:0] cov [NUM_COV];

    assign cov[0] = i_cov_0;
    assign cov[1] = i_cov_1;
    assign cov[2] = i_cov_2;
    assign cov[3] = i_cov_3;

    gcl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gcl_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_x_sample     (i_x_sample),
        .i_cov          (cov),
        .i_series_start (i_series_start),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_sigma_out    (o_sigma_out),
        .o_nll_term     (o_nll_term),
        .o_nll_total    (o_nll_total),
        .o_bad_variance (o_bad_variance)
    );

    // drop ready for the sample that was just taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready after accepting a request");

    // flagged series reports the fixed total
    a_bad_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_variance) |-> (o_nll_total == BAD_TOTAL_Q))
        else $error("flagged total mismatch");

    // a likelihood term only comes from a root, which is never negative
    a_term_sigma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_nll_term != '0)) |-> !o_sigma_out[DATA_W-1])
        else $error("negative sigma with a term");

endmodule
